// ===== design/pobr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the pixel offset to range and bearing block.
// No dependencies; every other design file but pobr_delay imports this package.
package pobr_pkg;

    // Port and field widths
    localparam int FRAME_W  = 12;
    localparam int COORD_W  = 11;
    localparam int DIST_W   = 16;
    localparam int BEAR_W   = 16;

    // Offset and square widths
    localparam int DX_W     = 13;
    localparam int MAG_W    = 12;
    localparam int SQR_W    = 2 * MAG_W;
    localparam int SUM_W    = SQR_W + 1;

    // Square root pipeline: radicand is the sum scaled by 256, padded to an even width
    localparam int RAD_W    = 34;
    localparam int SQ_DIG   = RAD_W / 2;
    localparam int SQ_REM_W = SQ_DIG + 4;
    localparam int SQ_LAT   = SQ_DIG + 2;

    // CORDIC datapath
    localparam int ANG_FRAC  = 16;
    localparam int CD_W      = 31;
    localparam int Z_W       = 25;
    localparam int ATAN_W    = 22;
    localparam int ATAN_N    = 24;
    localparam int DEG90_Q88 = 23040;

    // Defaults
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int COORD_BITS_DEF    = 11;
    localparam logic [FRAME_W-1:0] IMG_WIDTH_RESET  = 12'd640;
    localparam logic [FRAME_W-1:0] IMG_HEIGHT_RESET = 12'd480;

    typedef enum logic [0:0] {
        CFG_IMG_WIDTH  = 1'b0,
        CFG_IMG_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic dx_zero;
        logic ady_zero;
        logic dx_neg;
    } pobr_flags_t;

    // atan(2^-i) in degrees, units of 2^-16 degree
    localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_N] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

endpackage

// ===== design/pobr_delay.sv =====
`timescale 1ns / 1ps
// Fixed-length delay line for a valid bit and its payload, used to align pipeline branches.
// Depends on nothing.
module pobr_delay #(
    parameter int W     = 16,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         valid_in,
    input  logic [W-1:0] data_in,
    output logic         valid_out,
    output logic [W-1:0] data_out
);

    generate
        if (DEPTH == 0)
        begin : g_none
            assign valid_out = valid_in;
            assign data_out  = data_in;
        end
        else
        begin : g_line
            logic [DEPTH-1:0] vld_reg;
            logic [W-1:0]     data_reg [DEPTH];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg <= '0;
                end
                else
                begin
                    vld_reg[0] <= valid_in;
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        vld_reg[i] <= vld_reg[i-1];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                data_reg[0] <= data_in;
                for (int i = 1; i < DEPTH; i++)
                begin
                    data_reg[i] <= data_reg[i-1];
                end
            end

            assign valid_out = vld_reg[DEPTH-1];
            assign data_out  = data_reg[DEPTH-1];
        end
    endgenerate

endmodule

// ===== design/pobr_front.sv =====
`timescale 1ns / 1ps
// Front end: forms the offsets from the bottom-centre reference point, then their squares.
// Depends on pobr_pkg.
module pobr_front #(
    parameter int COORD_BITS = pobr_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              valid_in,
    input  logic [pobr_pkg::COORD_W-1:0]      x_pos,
    input  logic [pobr_pkg::COORD_W-1:0]      y_pos,
    input  logic [pobr_pkg::FRAME_W-1:0]      img_width,
    input  logic [pobr_pkg::FRAME_W-1:0]      img_height,
    output logic                              valid_out,
    output logic signed [pobr_pkg::DX_W-1:0]  dx,
    output logic [pobr_pkg::MAG_W-1:0]        ady,
    output pobr_pkg::pobr_flags_t             flags,
    output logic [pobr_pkg::SQR_W-1:0]        sqx,
    output logic [pobr_pkg::SQR_W-1:0]        sqy
);
    import pobr_pkg::*;

    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((32'd1 << COORD_BITS) - 32'd1);

    logic [COORD_W-1:0]      xm;
    logic [COORD_W-1:0]      ym;
    logic signed [DX_W-1:0]  dx_next;
    logic signed [DX_W-1:0]  dy_next;
    logic [MAG_W-1:0]        ady_next;
    pobr_flags_t             flags_next;

    logic                    vld_a_reg;
    logic signed [DX_W-1:0]  dx_a_reg;
    logic [MAG_W-1:0]        ady_a_reg;
    pobr_flags_t             flags_a_reg;
    logic [MAG_W-1:0]        adx_a;

    logic                    vld_b_reg;
    logic signed [DX_W-1:0]  dx_b_reg;
    logic [MAG_W-1:0]        ady_b_reg;
    pobr_flags_t             flags_b_reg;
    logic [SQR_W-1:0]        sqx_reg;
    logic [SQR_W-1:0]        sqy_reg;

    // Stage A: offsets
    always_comb
    begin
        xm      = x_pos & COORD_MASK;
        ym      = y_pos & COORD_MASK;
        dx_next = $signed({2'b00, img_width[FRAME_W-1:1]}) - $signed({2'b00, xm});
        dy_next = $signed({1'b0, img_height}) - $signed({2'b00, ym});
        ady_next = dy_next[DX_W-1] ? MAG_W'(-dy_next) : MAG_W'(dy_next);
        flags_next.dx_zero  = (dx_next == '0);
        flags_next.ady_zero = (dy_next == '0);
        flags_next.dx_neg   = dx_next[DX_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= valid_in;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_a_reg    <= dx_next;
        ady_a_reg   <= ady_next;
        flags_a_reg <= flags_next;
    end

    // Stage B: squares of the magnitudes
    assign adx_a = flags_a_reg.dx_neg ? MAG_W'(-dx_a_reg) : MAG_W'(dx_a_reg);

    always_ff @(posedge clk)
    begin
        dx_b_reg    <= dx_a_reg;
        ady_b_reg   <= ady_a_reg;
        flags_b_reg <= flags_a_reg;
        sqx_reg     <= adx_a * adx_a;
        sqy_reg     <= ady_a_reg * ady_a_reg;
    end

    assign valid_out = vld_b_reg;
    assign dx        = dx_b_reg;
    assign ady       = ady_b_reg;
    assign flags     = flags_b_reg;
    assign sqx       = sqx_reg;
    assign sqy       = sqy_reg;

endmodule

// ===== design/pobr_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined digit-by-digit square root of 256*(dx^2 + dy^2), rounded to nearest and
// saturated to Q12.4. Depends on pobr_pkg and pobr_delay.
module pobr_sqrt #(
    parameter int PAD = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  logic [pobr_pkg::SQR_W-1:0]    sqx,
    input  logic [pobr_pkg::SQR_W-1:0]    sqy,
    output logic                          valid_out,
    output logic [pobr_pkg::DIST_W-1:0]   distance
);
    import pobr_pkg::*;

    logic [SQ_REM_W-1:0] rem_reg  [0:SQ_DIG];
    logic [SQ_DIG-1:0]   root_reg [0:SQ_DIG];
    logic [RAD_W-1:0]    rad_reg  [0:SQ_DIG];
    logic [SQ_DIG:0]     vld_reg;

    logic                round_up;
    logic [SQ_DIG:0]     rounded;
    logic [DIST_W-1:0]   dist_next;
    logic [DIST_W-1:0]   dist_reg;
    logic                vld_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_out_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= {vld_reg[SQ_DIG-1:0], valid_in};
            vld_out_reg <= vld_reg[SQ_DIG];
        end
    end

    // Stage 0: load the radicand
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        rad_reg[0]  <= {1'b0, SUM_W'(sqx) + SUM_W'(sqy), 8'h00};
    end

    // One result bit per stage, most significant first
    generate
        for (genvar k = 1; k <= SQ_DIG; k++)
        begin : g_digit
            logic [SQ_REM_W-1:0] rem_sh;
            logic [SQ_REM_W-1:0] trial;
            logic                fits;

            assign rem_sh = {rem_reg[k-1][SQ_REM_W-3:0], rad_reg[k-1][RAD_W-1 -: 2]};
            assign trial  = SQ_REM_W'({root_reg[k-1], 2'b01});
            assign fits   = (rem_sh >= trial);

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= fits ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_reg[k-1][SQ_DIG-2:0], fits};
                rad_reg[k]  <= {rad_reg[k-1][RAD_W-3:0], 2'b00};
            end
        end
    endgenerate

    // Round to nearest: remainder above root means the true root is past the half step
    always_comb
    begin
        round_up  = (rem_reg[SQ_DIG] > SQ_REM_W'(root_reg[SQ_DIG]));
        rounded   = {1'b0, root_reg[SQ_DIG]} + (SQ_DIG + 1)'(round_up);
        dist_next = (rounded[SQ_DIG:DIST_W] != '0) ? {DIST_W{1'b1}} : rounded[DIST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
    end

    pobr_delay #(
        .W     (DIST_W),
        .DEPTH (PAD)
    ) u_align (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (vld_out_reg),
        .data_in   (dist_reg),
        .valid_out (valid_out),
        .data_out  (distance)
    );

endmodule

// ===== design/pobr_cordic.sv =====
`timescale 1ns / 1ps
// Unrolled CORDIC in vectoring mode: bearing atan(dx/|dy|) in degrees, rounded to Q8.8,
// clamped, with the axis and reference-point cases. Depends on pobr_pkg and pobr_delay.
module pobr_cordic #(
    parameter int CORDIC_STAGES = pobr_pkg::CORDIC_STAGES_DEF,
    parameter int PAD           = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              valid_in,
    input  logic signed [pobr_pkg::DX_W-1:0]  dx,
    input  logic [pobr_pkg::MAG_W-1:0]        ady,
    input  pobr_pkg::pobr_flags_t             flags,
    output logic                              valid_out,
    output logic signed [pobr_pkg::BEAR_W-1:0] bearing,
    output logic                              angle_undefined
);
    import pobr_pkg::*;

    localparam int N = CORDIC_STAGES;
    localparam logic signed [Z_W-1:0] POS90 = Z_W'(DEG90_Q88);
    localparam logic signed [Z_W-1:0] NEG90 = -POS90;
    localparam logic signed [Z_W-1:0] HALF_LSB = Z_W'(1 << (ANG_FRAC - 9));

    logic signed [CD_W-1:0] x_reg [0:N];
    logic signed [CD_W-1:0] y_reg [0:N];
    logic signed [Z_W-1:0]  z_reg [0:N];
    pobr_flags_t            fl_reg [0:N];
    logic [N:0]             vld_reg;

    logic signed [Z_W-1:0]    z_rnd;
    logic signed [Z_W-1:0]    z_q;
    logic signed [BEAR_W-1:0] bear_next;
    logic                     undef_next;
    logic signed [BEAR_W-1:0] bear_reg;
    logic                     undef_reg;
    logic                     vld_out_reg;
    logic [BEAR_W:0]          out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_out_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= {vld_reg[N-1:0], valid_in};
            vld_out_reg <= vld_reg[N];
        end
    end

    // Stage 0: vector (|dy|, dx) scaled by 2^16
    always_ff @(posedge clk)
    begin
        x_reg[0]  <= CD_W'({1'b0, ady}) <<< ANG_FRAC;
        y_reg[0]  <= CD_W'(dx) <<< ANG_FRAC;
        z_reg[0]  <= '0;
        fl_reg[0] <= flags;
    end

    // One micro-rotation per stage, driving y towards zero
    generate
        for (genvar k = 1; k <= N; k++)
        begin : g_iter
            localparam int I = k - 1;
            logic signed [CD_W-1:0] xs;
            logic signed [CD_W-1:0] ys;
            logic signed [Z_W-1:0]  step;

            assign xs   = x_reg[k-1] >>> I;
            assign ys   = y_reg[k-1] >>> I;
            assign step = $signed(Z_W'(ATAN_TAB[I]));

            always_ff @(posedge clk)
            begin
                if (!y_reg[k-1][CD_W-1])
                begin
                    x_reg[k] <= x_reg[k-1] + ys;
                    y_reg[k] <= y_reg[k-1] - xs;
                    z_reg[k] <= z_reg[k-1] + step;
                end
                else
                begin
                    x_reg[k] <= x_reg[k-1] - ys;
                    y_reg[k] <= y_reg[k-1] + xs;
                    z_reg[k] <= z_reg[k-1] - step;
                end
                fl_reg[k] <= fl_reg[k-1];
            end
        end
    endgenerate

    // Round into Q8.8 (ties upward), clamp, then override on the axes
    always_comb
    begin
        z_rnd      = z_reg[N] + HALF_LSB;
        z_q        = z_rnd >>> (ANG_FRAC - 8);
        undef_next = fl_reg[N].dx_zero && fl_reg[N].ady_zero;
        if (fl_reg[N].dx_zero)
        begin
            bear_next = '0;
        end
        else if (fl_reg[N].ady_zero)
        begin
            bear_next = fl_reg[N].dx_neg ? BEAR_W'(NEG90) : BEAR_W'(POS90);
        end
        else if (z_q > POS90)
        begin
            bear_next = BEAR_W'(POS90);
        end
        else if (z_q < NEG90)
        begin
            bear_next = BEAR_W'(NEG90);
        end
        else
        begin
            bear_next = BEAR_W'(z_q);
        end
    end

    always_ff @(posedge clk)
    begin
        bear_reg  <= bear_next;
        undef_reg <= undef_next;
    end

    pobr_delay #(
        .W     (BEAR_W + 1),
        .DEPTH (PAD)
    ) u_align (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (vld_out_reg),
        .data_in   ({undef_reg, bear_reg}),
        .valid_out (valid_out),
        .data_out  (out_data)
    );

    assign angle_undefined = out_data[BEAR_W];
    assign bearing         = $signed(out_data[BEAR_W-1:0]);

endmodule

// ===== design/pixel_offset_to_range_bearing_top.sv =====
`timescale 1ns / 1ps
// Top level: configuration registers, front end, square root and CORDIC pipelines.
// Depends on pobr_pkg, pobr_front, pobr_sqrt, pobr_cordic and pobr_delay.

// Takes one pixel position per clock: a transaction is accepted whenever start is high,
// and busy never rises. Every transaction gives exactly one result, on done for a single
// cycle. The slower of the square root pipeline (one root bit per stage) and the unrolled
// CORDIC sets when the result appears, and the faster branch is padded to match. Results
// come out in order and cannot be held off, so the receiver must take each one as it appears.
// distance is unsigned Q12.4, saturating at 65535; bearing is signed Q8.8 degrees, positive left.
// Write the image width and height registers only while no transaction is in flight.
module pixel_offset_to_range_bearing_top #(
    parameter int CORDIC_STAGES = pobr_pkg::CORDIC_STAGES_DEF,
    parameter int COORD_BITS    = pobr_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [pobr_pkg::COORD_W-1:0]       x_pos,
    input  logic [pobr_pkg::COORD_W-1:0]       y_pos,
    input  logic                               cfg_we,
    input  pobr_pkg::cfg_index_t               cfg_index,
    input  logic [pobr_pkg::FRAME_W-1:0]       cfg_data,
    output logic                               done,
    output logic [pobr_pkg::DIST_W-1:0]        distance,
    output logic signed [pobr_pkg::BEAR_W-1:0] bearing,
    output logic                               angle_undefined
);
    import pobr_pkg::*;

    localparam int CD_LAT = CORDIC_STAGES + 2;
    localparam int LAT    = (CD_LAT > SQ_LAT) ? CD_LAT : SQ_LAT;
    localparam logic signed [BEAR_W-1:0] BEAR_MAX = BEAR_W'(DEG90_Q88);
    localparam logic signed [BEAR_W-1:0] BEAR_MIN = -BEAR_MAX;

    logic [FRAME_W-1:0] img_width_reg;
    logic [FRAME_W-1:0] img_height_reg;

    logic               accept;
    logic               vld_f;
    logic signed [DX_W-1:0] dx_f;
    logic [MAG_W-1:0]   ady_f;
    pobr_flags_t        flags_f;
    logic [SQR_W-1:0]   sqx_f;
    logic [SQR_W-1:0]   sqy_f;
    logic               vld_sq;
    logic               vld_cd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_width_reg  <= IMG_WIDTH_RESET;
            img_height_reg <= IMG_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMG_WIDTH:  img_width_reg  <= cfg_data;
                CFG_IMG_HEIGHT: img_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Fully pipelined: take a transaction every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    pobr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (accept),
        .x_pos      (x_pos),
        .y_pos      (y_pos),
        .img_width  (img_width_reg),
        .img_height (img_height_reg),
        .valid_out  (vld_f),
        .dx         (dx_f),
        .ady        (ady_f),
        .flags      (flags_f),
        .sqx        (sqx_f),
        .sqy        (sqy_f)
    );

    pobr_sqrt #(
        .PAD (LAT - SQ_LAT)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (vld_f),
        .sqx       (sqx_f),
        .sqy       (sqy_f),
        .valid_out (vld_sq),
        .distance  (distance)
    );

    pobr_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .PAD           (LAT - CD_LAT)
    ) u_cordic (
        .clk             (clk),
        .rst_n           (rst_n),
        .valid_in        (vld_f),
        .dx              (dx_f),
        .ady             (ady_f),
        .flags           (flags_f),
        .valid_out       (vld_cd),
        .bearing         (bearing),
        .angle_undefined (angle_undefined)
    );

    assign done = vld_sq;

    // Both branches must deliver the same transaction in the same cycle
    a_branch_align: assert property (@(posedge clk) disable iff (!rst_n)
        vld_sq == vld_cd)
        else $error("square root and CORDIC branches out of step");

    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && angle_undefined |-> (distance == '0) && (bearing == '0))
        else $error("reference point hit with non-zero distance or bearing");

    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (bearing <= BEAR_MAX) && (bearing >= BEAR_MIN))
        else $error("bearing outside +/-90 degrees");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for pixel_offset_to_range_bearing_top: directed and random pixel positions
// under several frame sizes, each result checked against an in-bench range/bearing predictor.
// Depends on pobr_pkg and the design files under design/.
module tb;
    import pobr_pkg::*;

    localparam int STAGES         = CORDIC_STAGES_DEF;
    localparam int PIPE_LATENCY   = 2 + ((STAGES + 2 > 19) ? STAGES + 2 : 19);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_SET  = 165;

    typedef struct packed {
        logic [DIST_W-1:0]        distance;
        logic signed [BEAR_W-1:0] bearing;
        logic                     angle_undefined;
    } range_bearing_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [COORD_W-1:0]        x_pos;
    logic [COORD_W-1:0]        y_pos;
    logic                      cfg_we;
    cfg_index_t                cfg_index;
    logic [FRAME_W-1:0]        cfg_data;
    logic                      done;
    logic [DIST_W-1:0]         distance;
    logic signed [BEAR_W-1:0]  bearing;
    logic                      angle_undefined;

    logic [FRAME_W-1:0]        img_width_shadow;
    logic [FRAME_W-1:0]        img_height_shadow;
    range_bearing_t            pending_fixes[$];
    int                        mismatches;
    int                        sender_idle_pct;
    int                        idle_cycles;

    pixel_offset_to_range_bearing_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .x_pos           (x_pos),
        .y_pos           (y_pos),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .distance        (distance),
        .bearing         (bearing),
        .angle_undefined (angle_undefined)
    );

    always #5 clk = ~clk;

    // Largest r with r*r <= n
    function automatic longint floor_sqrt(input longint n);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 64'd1 << 20;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic range_bearing_t predict_range_bearing(input logic [COORD_W-1:0] xp,
                                                             input logic [COORD_W-1:0] yp);
        longint dx;
        longint dy;
        longint ady;
        longint radicand;
        longint root;
        longint xv;
        longint yv;
        longint xs;
        longint ys;
        longint z;
        longint deg;
        range_bearing_t fix;
        dx  = longint'(img_width_shadow >> 1) - longint'(xp);
        dy  = longint'(img_height_shadow) - longint'(yp);
        ady = (dy < 0) ? -dy : dy;

        // Q12.4 distance: root of the squared offset scaled by 256, rounded to nearest
        radicand = (dx * dx + ady * ady) * 256;
        root = floor_sqrt(radicand);
        if (radicand - root * root > root)
            root = root + 1;
        if (root > 65535)
            root = 65535;

        fix.angle_undefined = 1'b0;
        if (dx == 0 && ady == 0)
        begin
            deg = 0;
            fix.angle_undefined = 1'b1;
        end
        else if (dx == 0)
            deg = 0;
        else if (ady == 0)
            deg = (dx > 0) ? DEG90_Q88 : -DEG90_Q88;
        else
        begin
            // Vectoring: drive y to zero, accumulate angle in 2^-16 degree
            xv = ady * 65536;
            yv = dx * 65536;
            z  = 0;
            for (int i = 0; i < STAGES; i++)
            begin
                xs = xv >>> i;
                ys = yv >>> i;
                if (yv >= 0)
                begin
                    xv = xv + ys;
                    yv = yv - xs;
                    z  = z + longint'(ATAN_TAB[i]);
                end
                else
                begin
                    xv = xv - ys;
                    yv = yv + xs;
                    z  = z - longint'(ATAN_TAB[i]);
                end
            end
            deg = (z + 128) >>> 8;
            if (deg > DEG90_Q88)
                deg = DEG90_Q88;
            if (deg < -DEG90_Q88)
                deg = -DEG90_Q88;
        end
        fix.distance = root[DIST_W-1:0];
        fix.bearing  = deg[BEAR_W-1:0];
        return fix;
    endfunction

    // Track register writes and accepted transactions
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
        begin
            if (cfg_index == CFG_IMG_WIDTH)
                img_width_shadow <= cfg_data;
            else
                img_height_shadow <= cfg_data;
        end
        if (rst_n && start && !busy)
            pending_fixes.push_back(predict_range_bearing(x_pos, y_pos));
    end

    // Results cannot be held off: check each one on the cycle it appears
    always @(posedge clk)
    begin
        range_bearing_t want;
        if (rst_n && done)
        begin
            if (pending_fixes.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing expected: distance %0d bearing %0d",
                         $time, distance, bearing);
            end
            else
            begin
                want = pending_fixes.pop_front();
                if (want.distance !== distance)
                begin
                    mismatches++;
                    $display("%0t: distance expected %0d actual %0d",
                             $time, want.distance, distance);
                end
                if (want.bearing !== bearing)
                begin
                    mismatches++;
                    $display("%0t: bearing expected %0d actual %0d",
                             $time, want.bearing, bearing);
                end
                if (want.angle_undefined !== angle_undefined)
                begin
                    mismatches++;
                    $display("%0t: angle_undefined expected %0b actual %0b",
                             $time, want.angle_undefined, angle_undefined);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_position(input int x, input int y);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        x_pos <= x[COORD_W-1:0];
        y_pos <= y[COORD_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_fixes.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_frame(input int width, input int height);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IMG_WIDTH;
        cfg_data  <= width[FRAME_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_IMG_HEIGHT;
        cfg_data  <= height[FRAME_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic int clamp_coord(input int v);
        if (v < 0)
            return 0;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    task automatic send_random_position();
        int half;
        int x;
        int y;
        half = int'(img_width_shadow >> 1);
        x = $urandom_range(2047);
        y = $urandom_range(2047);
        case ($urandom_range(9))
            6:  // around the reference point
            begin
                x = clamp_coord(half + int'($urandom_range(8)) - 4);
                y = clamp_coord(int'(img_height_shadow) + int'($urandom_range(8)) - 4);
            end
            7: x = clamp_coord(half);
            8: y = clamp_coord(int'(img_height_shadow));
            9:
            begin
                x = $urandom_range(1) ? 2047 : 0;
                y = $urandom_range(1) ? 2047 : 0;
            end
            default: ;
        endcase
        send_position(x, y);
    endtask

    // Reset frame size: reference hit, both vertical-zero directions, centre column,
    // points just beside the reference, corners and alternating bit patterns
    task automatic test_reset_frame();
        sender_idle_pct = 0;
        send_position(320, 480);
        send_position(0, 480);
        send_position(2047, 480);
        send_position(320, 0);
        send_position(320, 2047);
        send_position(0, 0);
        send_position(2047, 2047);
        send_position(0, 2047);
        send_position(2047, 0);
        send_position(321, 479);
        send_position(319, 481);
        send_position(1365, 682);
        send_position(682, 1365);
        wait_until_drained();
    endtask

    // Extreme and odd frame sizes, including ones large enough to saturate distance
    task automatic test_frame_extremes();
        sender_idle_pct = 0;
        write_frame(2, 1);
        send_position(1, 1);
        send_position(0, 0);
        send_position(2047, 2047);
        wait_until_drained();
        write_frame(2048, 2048);
        send_position(1024, 2048 - 1);
        send_position(0, 0);
        send_position(2047, 0);
        wait_until_drained();
        write_frame(4095, 4095);
        send_position(0, 0);
        send_position(2047, 0);
        send_position(0, 2047);
        wait_until_drained();
        write_frame(1023, 777);
        send_position(511, 777);
        send_position(512, 100);
        wait_until_drained();
    endtask

    task automatic test_random_sweep();
        int widths[6];
        int heights[6];
        int idle_pcts[3];
        widths    = '{640, 2048, 2, 1023, 4095, 0};
        heights   = '{480, 2048, 1, 777, 4095, 0};
        idle_pcts = '{0, 63, 22};
        widths[5]  = $urandom_range(2048, 2);
        heights[5] = $urandom_range(2048, 1);
        for (int set = 0; set < 6; set++)
        begin
            write_frame(widths[set], heights[set]);
            sender_idle_pct = idle_pcts[set % 3];
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                // occasional burst with no gaps
                if ($urandom_range(199) == 0)
                    sender_idle_pct = 0;
                else if ($urandom_range(199) == 0)
                    sender_idle_pct = idle_pcts[set % 3];
                send_random_position();
            end
            wait_until_drained();
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        x_pos       = '0;
        y_pos       = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_IMG_WIDTH;
        cfg_data    = '0;
        mismatches  = 0;
        idle_cycles = 0;
        sender_idle_pct   = 0;
        img_width_shadow  = IMG_WIDTH_RESET;
        img_height_shadow = IMG_HEIGHT_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_frame();
        test_frame_extremes();
        test_random_sweep();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
